>>> src/bvs_pkg.sv
// Shared types and codes for the bit vector set engine.
package bvs_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CUT    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_CUT,
    S_LAST
  } state_e;

  typedef enum logic [1:0] {
    RA_REQ,
    RA_K1,
    RA_K2
  } rd_sel_e;

  typedef enum logic [1:0] {
    WD_SET,
    WD_CLR,
    WD_CARRY,
    WD_HELD
  } wr_sel_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [9:0] element;
  } in_t;

  typedef struct packed {
    logic member;
    logic status;
  } out_t;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    hold_op;
    logic    hold_shift;
    logic    k_inc;
    logic    out_ld;
    logic    out_rej;
  } cmd_t;

  typedef struct packed {
    logic reject;
    req_e req;
    logic last_op;
    logic last_cut;
  } stat_t;

endpackage

>>> src/bvs_ctrl.sv
// Controller state machine sequencing requests and cut walks.
module bvs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  bvs_pkg::stat_t stat_i,
  output bvs_pkg::cmd_t  cmd_o
);

  bvs_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;

  assign in_stall_o  = (state_q != bvs_pkg::S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bvs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bvs_pkg::S_IDLE: begin
        if (accept && !stat_i.reject) state_d = bvs_pkg::S_OP;
      end
      bvs_pkg::S_OP: begin
        if (stat_i.req != bvs_pkg::REQ_CUT) state_d = bvs_pkg::S_IDLE;
        else if (stat_i.last_op) state_d = bvs_pkg::S_LAST;
        else state_d = bvs_pkg::S_CUT;
      end
      bvs_pkg::S_CUT: begin
        if (stat_i.last_cut) state_d = bvs_pkg::S_LAST;
      end
      bvs_pkg::S_LAST: state_d = bvs_pkg::S_IDLE;
      default: state_d = bvs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{latch: 1'b0, rd_en: 1'b0, rd_sel: bvs_pkg::RA_REQ, wr_en: 1'b0,
              wr_sel: bvs_pkg::WD_HELD, hold_op: 1'b0, hold_shift: 1'b0,
              k_inc: 1'b0, out_ld: 1'b0, out_rej: 1'b0};
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      bvs_pkg::S_IDLE: begin
        if (accept) begin
          if (stat_i.reject) begin
            cmd_o.out_ld  = 1'b1;
            cmd_o.out_rej = 1'b1;
            out_valid_d   = 1'b1;
          end else begin
            cmd_o.latch = 1'b1;
            cmd_o.rd_en = 1'b1;
          end
        end
      end
      bvs_pkg::S_OP: begin
        unique case (stat_i.req)
          bvs_pkg::REQ_INSERT: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = bvs_pkg::WD_SET;
            cmd_o.out_ld = 1'b1;
            out_valid_d  = 1'b1;
          end
          bvs_pkg::REQ_DELETE: begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = bvs_pkg::WD_CLR;
            cmd_o.out_ld = 1'b1;
            out_valid_d  = 1'b1;
          end
          bvs_pkg::REQ_QUERY: begin
            cmd_o.out_ld = 1'b1;
            out_valid_d  = 1'b1;
          end
          default: begin
            cmd_o.hold_op = 1'b1;
            if (!stat_i.last_op) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = bvs_pkg::RA_K1;
            end
          end
        endcase
      end
      bvs_pkg::S_CUT: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_sel     = bvs_pkg::WD_CARRY;
        cmd_o.hold_shift = 1'b1;
        cmd_o.k_inc      = 1'b1;
        if (!stat_i.last_cut) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = bvs_pkg::RA_K2;
        end
      end
      bvs_pkg::S_LAST: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bvs_pkg::WD_HELD;
        cmd_o.out_ld = 1'b1;
        out_valid_d  = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> src/bvs_dpath.sv
// Datapath: word store, request registers, cut shifter and result register.
module bvs_dpath #(
  parameter int NUM_WORDS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bvs_pkg::in_t   in_data_i,
  input  logic           cfg_we_i,
  input  logic [4:0]     cfg_wdata_i,
  input  bvs_pkg::cmd_t  cmd_i,
  output bvs_pkg::stat_t stat_o,
  output bvs_pkg::out_t  out_data_o
);

  localparam int DEPTH = (NUM_WORDS > 31) ? 31 : NUM_WORDS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [4:0] NMAX = 5'(DEPTH);

  logic [63:0]   mem [DEPTH];
  logic          vld_q [DEPTH];
  logic [63:0]   rdata_q;
  logic          rvld_q;
  logic [4:0]    cfg_q;
  bvs_pkg::req_e req_q;
  logic [5:0]    pos_q;
  logic [4:0]    k_q;
  logic [63:0]   held_q;
  bvs_pkg::out_t out_q;

  logic [4:0]  n;
  logic [4:0]  n_m1;
  logic [4:0]  in_w;
  logic [4:0]  ra;
  logic [63:0] word;
  logic [63:0] bit_m;
  logic [63:0] low_m;
  logic [63:0] keep_m;
  logic [63:0] below_m;
  logic [63:0] cut_w;
  logic [63:0] wd;

  assign n      = (cfg_q > NMAX) ? NMAX : cfg_q;
  assign n_m1   = n - 5'd1;
  assign in_w   = {1'b0, in_data_i.element[9:6]};
  assign word   = rvld_q ? rdata_q : 64'd0;
  assign bit_m  = 64'h8000_0000_0000_0000 >> pos_q;
  assign low_m  = {64{1'b1}} >> pos_q;
  assign keep_m = ~low_m;
  assign below_m = low_m >> 1;
  assign cut_w  = (word & keep_m) | ((word & below_m) << 1);

  assign stat_o.reject   = (in_w >= n);
  assign stat_o.req      = req_q;
  assign stat_o.last_op  = (k_q == n_m1);
  assign stat_o.last_cut = ((k_q + 5'd1) == n_m1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      bvs_pkg::RA_K1: ra = k_q + 5'd1;
      bvs_pkg::RA_K2: ra = k_q + 5'd2;
      default:        ra = in_w;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      bvs_pkg::WD_SET:   wd = word | bit_m;
      bvs_pkg::WD_CLR:   wd = word & ~bit_m;
      bvs_pkg::WD_CARRY: wd = held_q | {63'd0, word[63]};
      default:           wd = held_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[k_q[AW-1:0]] <= wd;
    if (cmd_i.rd_en) rdata_q <= mem[ra[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
      rvld_q <= 1'b0;
      cfg_q  <= 5'd16;
    end else begin
      if (cmd_i.wr_en) vld_q[k_q[AW-1:0]] <= 1'b1;
      if (cmd_i.rd_en) rvld_q <= vld_q[ra[AW-1:0]];
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= bvs_pkg::req_e'(in_data_i.req_type);
      pos_q <= in_data_i.element[5:0];
    end
    if (cmd_i.latch) k_q <= in_w;
    else if (cmd_i.k_inc) k_q <= k_q + 5'd1;
    if (cmd_i.hold_op) held_q <= cut_w;
    else if (cmd_i.hold_shift) held_q <= word << 1;
    if (cmd_i.out_ld) begin
      if (cmd_i.out_rej) begin
        out_q.member <= 1'b0;
        out_q.status <= 1'b1;
      end else begin
        out_q.member <= (req_q == bvs_pkg::REQ_QUERY) && ((word & bit_m) != 64'd0);
        out_q.status <= 1'b0;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

>>> src/bit_vector_set_engine_core.sv
// Top level of the bit vector set engine: controller plus datapath.
//
// Input channel carries one request item (req_type, element); the output
// channel returns one item (member, status) per request. Both use valid and
// stall; an item moves when valid is high and stall is low.
// One request is in work at a time. Steps from accept to result valid:
//   rejected element (word not in use): result loaded on accept
//   insert, delete, query: word read, then update
//   cut: words w to n - 1 rewritten, n = words in use, w = element word; the walk
//   updates one word per cycle through the single write port of the store.
// A new item is taken in the cycle the previous result is registered,
// provided the output register is free.
// A stalled result holds in the output register; the input stalls while
// it holds.
// The user must write the words_in_use register by cfg_we_i / cfg_wdata_i only
// while idle; the block does not enforce this. Reset empties the set at once
// through per-word valid bits and sets words_in_use to 16.
module bit_vector_set_engine_core #(
  parameter int NUM_WORDS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bvs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bvs_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [4:0]    cfg_wdata_i
);

  bvs_pkg::cmd_t  cmd;
  bvs_pkg::stat_t stat;

  bvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bvs_dpath #(
    .NUM_WORDS (NUM_WORDS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule
